[design/gcior_pkg.sv]
// gcior_pkg: shared constants, codes and the front-to-back command word
// for the in-order group release block. No dependencies.
package gcior_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_ITEMS_DEF  = 256;
  localparam int MAX_GROUPS_DEF = 32;

  // Release results per input word, and a counter wide enough to hold it
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = 6;

  // Port field widths
  localparam int OP_W   = 2;
  localparam int ITEM_W = 8;
  localparam int GID_W  = 5;
  localparam int KIND_W = 3;

  // Group counts saturate at the top of their range
  localparam int               SIZE_W   = 9;
  localparam logic [SIZE_W-1:0] SIZE_SAT = 9'd511;

  // Group index carried in a command word (covers the largest group count)
  localparam int GROUP_W = 6;

  // Input operations
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PREP  = 2'd2,
    OP_MARK  = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASE = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_RANGE   = 3'd2,
    KIND_ORDER   = 3'd3,
    KIND_UNARMED = 3'd4
  } kind_e;

  // Classified commands from front to back
  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_PREP  = 3'd2,
    CMD_MARK  = 3'd3,
    CMD_ERR   = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               old_valid;  // load: item was already mapped
    logic [GROUP_W-1:0] old_group;  // load: group the item leaves
    logic [GROUP_W-1:0] group;      // load: new group; mark: item's group
  } cmd_t;

endpackage

[design/gcior_front.sv]
// gcior_front: accepts input words, owns the item-to-group map and turns
// each word into a classified command for the back end. Uses gcior_pkg.
module gcior_front #(
  parameter int MAX_ITEMS  = gcior_pkg::MAX_ITEMS_DEF,
  parameter int MAX_GROUPS = gcior_pkg::MAX_GROUPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gcior_pkg::OP_W-1:0]   op_i,
  input  logic [gcior_pkg::ITEM_W-1:0] item_index_i,
  input  logic [gcior_pkg::GID_W-1:0]  group_id_i,
  output gcior_pkg::cmd_t              cmd_o,
  output logic                         cmd_push_o,
  input  logic                         cmd_full_i
);
  import gcior_pkg::*;

  // Only items reachable through the index field need storage
  localparam int ItemSpace = 1 << ITEM_W;
  localparam int ItemsEff  = (MAX_ITEMS < ItemSpace) ? MAX_ITEMS : ItemSpace;
  localparam int IW        = $clog2(ItemsEff);
  localparam int GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam logic [ITEM_W:0] ItemsLim  = (ITEM_W + 1)'(ItemsEff);
  localparam logic [GID_W+1:0] GroupsLim = (GID_W + 2)'(MAX_GROUPS);

  logic                busy_q;
  op_e                 op_q;
  logic [ITEM_W-1:0]   item_q;
  logic [GID_W-1:0]    gid_q;
  logic [GW-1:0]       grp_mem [ItemsEff];
  logic [GW-1:0]       rd_grp_q;
  logic [ItemsEff-1:0] mapped_q;

  logic          accept;
  logic          in_range_in;
  logic          item_ok;
  logic          gid_ok;
  logic          mapped_hit;
  logic          decide;
  logic          map_wr;
  logic          map_clr;
  logic [IW-1:0] idx;

  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign in_range_in = {1'b0, item_index_i} < ItemsLim;

  assign idx        = item_q[IW-1:0];
  assign item_ok    = {1'b0, item_q} < ItemsLim;
  assign gid_ok     = {2'b00, gid_q} < GroupsLim;
  assign mapped_hit = item_ok && mapped_q[idx];
  assign decide     = busy_q && !cmd_full_i;
  assign cmd_push_o = decide;

  // Classify the held word
  always_comb begin
    cmd_o           = '0;
    cmd_o.cmd       = CMD_ERR;
    map_wr          = 1'b0;
    map_clr         = 1'b0;
    unique case (op_q)
      OP_CLEAR: begin
        cmd_o.cmd = CMD_CLEAR;
        map_clr   = decide;
      end
      OP_LOAD: begin
        if (item_ok && gid_ok) begin
          cmd_o.cmd       = CMD_LOAD;
          cmd_o.old_valid = mapped_hit;
          cmd_o.old_group = GROUP_W'(rd_grp_q);
          cmd_o.group     = GROUP_W'(gid_q);
          map_wr          = decide;
        end
      end
      OP_PREP: cmd_o.cmd = CMD_PREP;
      OP_MARK: begin
        if (mapped_hit) begin
          cmd_o.cmd   = CMD_MARK;
          cmd_o.group = GROUP_W'(rd_grp_q);
        end
      end
      default: cmd_o.cmd = CMD_ERR;
    endcase
  end

  // Word holding register; map read is issued as the word comes in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      item_q <= item_index_i;
      gid_q  <= group_id_i;
    end
  end

  // Item-to-group map, registered read
  always_ff @(posedge clk_i) begin
    if (accept && in_range_in) begin
      rd_grp_q <= grp_mem[item_index_i[IW-1:0]];
    end
    if (map_wr) begin
      grp_mem[idx] <= GW'(gid_q);
    end
  end

  // Busy flag and mapped bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      mapped_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (decide) begin
        busy_q <= 1'b0;
      end
      if (map_clr) begin
        mapped_q <= '0;
      end else if (map_wr) begin
        mapped_q[idx] <= 1'b1;
      end
    end
  end

endmodule

[design/gcior_queue.sv]
// gcior_queue: two-entry command queue between front and back end.
// Uses gcior_pkg for the command word.
module gcior_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gcior_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output gcior_pkg::cmd_t data_o,
  output logic            empty_o
);
  import gcior_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[design/gcior_back.sv]
// gcior_back: executes commands against group sizes and pending counts,
// walks the release pointer and drives the result register. Uses gcior_pkg.
module gcior_back #(
  parameter int MAX_GROUPS = gcior_pkg::MAX_GROUPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gcior_pkg::cmd_t              cmd_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gcior_pkg::KIND_W-1:0] kind_o,
  output logic [gcior_pkg::GID_W-1:0]  released_group_o,
  output logic                         all_issued_o,
  output logic                         last_o
);
  import gcior_pkg::*;

  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int RPW = GW + 1;
  localparam logic [GW-1:0]        LastGroup = GW'(MAX_GROUPS - 1);
  localparam logic [RES_CNT_W-1:0] ResLimit  = RES_CNT_W'(MAX_RESULTS);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_RESP    = 13'b0000000000010,
    ST_LD_RDO  = 13'b0000000000100,
    ST_LD_WRO  = 13'b0000000001000,
    ST_LD_RDN  = 13'b0000000010000,
    ST_LD_WRN  = 13'b0000000100000,
    ST_PREP_RD = 13'b0000001000000,
    ST_PREP_WR = 13'b0000010000000,
    ST_MK_RD   = 13'b0000100000000,
    ST_MK_WR   = 13'b0001000000000,
    ST_WK_RD   = 13'b0010000000000,
    ST_WK_CHK  = 13'b0100000000000,
    ST_WK_EMIT = 13'b1000000000000
  } state_e;

  state_e                 state_q, state_d;
  logic                   armed_q, armed_d;
  logic [RPW-1:0]         rp_q, rp_d;
  logic [RPW-1:0]         giu_q, giu_d;
  logic [GW-1:0]          cnt_q, cnt_d;
  logic [RES_CNT_W-1:0]   n_q, n_d;
  kind_e                  resp_kind_q, resp_kind_d;
  cmd_t                   cmd_q, cmd_d;

  // Group size store with valid bits, pending count store
  logic [SIZE_W-1:0]      size_mem [MAX_GROUPS];
  logic [MAX_GROUPS-1:0]  size_v_q;
  logic [SIZE_W-1:0]      size_rd_q;
  logic                   size_rv_q;
  logic [SIZE_W-1:0]      pend_mem [MAX_GROUPS];
  logic [SIZE_W-1:0]      pend_rd_q;

  // Result register
  logic                   out_valid_q;
  kind_e                  out_kind_q;
  logic [GID_W-1:0]       out_grp_q;
  logic                   out_all_q;
  logic                   out_last_q;

  logic                   size_clr, size_ren, size_wen;
  logic [GW-1:0]          size_raddr, size_waddr;
  logic [SIZE_W-1:0]      size_wdata;
  logic                   pend_ren, pend_wen;
  logic [GW-1:0]          pend_raddr, pend_waddr;
  logic [SIZE_W-1:0]      pend_wdata;
  logic                   emit;
  kind_e                  emit_kind;
  logic [GID_W-1:0]       emit_grp;
  logic                   emit_all;
  logic                   emit_last;

  logic                   out_free;
  logic [SIZE_W-1:0]      sval;
  logic [GW-1:0]          g_cur, g_old, g_in;
  logic [RPW-1:0]         rp_p1, rp_p2, new_p1;
  logic                   nxt_ok;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sval     = size_rv_q ? size_rd_q : '0;
  assign g_cur    = cmd_q.group[GW-1:0];
  assign g_old    = cmd_q.old_group[GW-1:0];
  assign g_in     = cmd_i.group[GW-1:0];
  assign rp_p1    = rp_q + RPW'(1);
  assign rp_p2    = rp_q + RPW'(2);
  assign new_p1   = {1'b0, g_cur} + RPW'(1);
  assign nxt_ok   = (RES_CNT_W'(n_q + 1'b1) < ResLimit) && (rp_p1 < giu_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    rp_d        = rp_q;
    giu_d       = giu_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    resp_kind_d = resp_kind_q;
    cmd_d       = cmd_q;
    cmd_pop_o   = 1'b0;
    size_clr    = 1'b0;
    size_ren    = 1'b0;
    size_raddr  = cnt_q;
    size_wen    = 1'b0;
    size_waddr  = g_old;
    size_wdata  = sval;
    pend_ren    = 1'b0;
    pend_raddr  = g_cur;
    pend_wen    = 1'b0;
    pend_waddr  = g_cur;
    pend_wdata  = pend_rd_q - 1'b1;
    emit        = 1'b0;
    emit_kind   = resp_kind_q;
    emit_grp    = '0;
    emit_all    = rp_q >= giu_q;
    emit_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.cmd)
            CMD_CLEAR: begin
              size_clr    = 1'b1;
              armed_d     = 1'b0;
              rp_d        = '0;
              giu_d       = '0;
              resp_kind_d = KIND_ACK;
              state_d     = ST_RESP;
            end
            CMD_LOAD: begin
              state_d = cmd_i.old_valid ? ST_LD_RDO : ST_LD_RDN;
            end
            CMD_PREP: begin
              armed_d = 1'b1;
              rp_d    = '0;
              cnt_d   = '0;
              state_d = ST_PREP_RD;
            end
            CMD_MARK: begin
              if (!armed_q) begin
                resp_kind_d = KIND_UNARMED;
                state_d     = ST_RESP;
              end else if ({1'b0, g_in} < rp_q) begin
                resp_kind_d = KIND_ORDER;
                state_d     = ST_RESP;
              end else begin
                state_d = ST_MK_RD;
              end
            end
            default: begin
              resp_kind_d = KIND_RANGE;
              state_d     = ST_RESP;
            end
          endcase
        end
      end
      // Single closing result
      ST_RESP: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      // Load: old group shrinks, new group grows
      ST_LD_RDO: begin
        size_ren   = 1'b1;
        size_raddr = g_old;
        state_d    = ST_LD_WRO;
      end
      ST_LD_WRO: begin
        if (sval != '0) begin
          size_wen   = 1'b1;
          size_waddr = g_old;
          size_wdata = sval - 1'b1;
        end
        state_d = ST_LD_RDN;
      end
      ST_LD_RDN: begin
        size_ren   = 1'b1;
        size_raddr = g_cur;
        state_d    = ST_LD_WRN;
      end
      ST_LD_WRN: begin
        size_wen   = 1'b1;
        size_waddr = g_cur;
        size_wdata = (sval == SIZE_SAT) ? sval : SIZE_W'(sval + 1'b1);
        if (new_p1 > giu_q) giu_d = new_p1;
        resp_kind_d = KIND_ACK;
        state_d     = ST_RESP;
      end
      // Prepare: copy every size into its pending count
      ST_PREP_RD: begin
        size_ren   = 1'b1;
        size_raddr = cnt_q;
        state_d    = ST_PREP_WR;
      end
      ST_PREP_WR: begin
        pend_wen   = 1'b1;
        pend_waddr = cnt_q;
        pend_wdata = sval;
        if (cnt_q == LastGroup) begin
          resp_kind_d = KIND_ACK;
          state_d     = ST_RESP;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_PREP_RD;
        end
      end
      // Mark: count down the item's group
      ST_MK_RD: begin
        pend_ren   = 1'b1;
        pend_raddr = g_cur;
        state_d    = ST_MK_WR;
      end
      ST_MK_WR: begin
        if (pend_rd_q == '0) begin
          resp_kind_d = KIND_ORDER;
          state_d     = ST_RESP;
        end else begin
          pend_wen   = 1'b1;
          pend_waddr = g_cur;
          n_d        = '0;
          state_d    = ST_WK_RD;
        end
      end
      // Release walk: look at the pointed group
      ST_WK_RD: begin
        if (rp_q < giu_q) begin
          pend_ren   = 1'b1;
          pend_raddr = rp_q[GW-1:0];
          state_d    = ST_WK_CHK;
        end else begin
          resp_kind_d = KIND_ACK;
          state_d     = ST_RESP;
        end
      end
      ST_WK_CHK: begin
        if (pend_rd_q == '0) begin
          // fetch the following group to know whether this release closes
          if (rp_p1 < giu_q) begin
            pend_ren   = 1'b1;
            pend_raddr = rp_p1[GW-1:0];
          end
          state_d = ST_WK_EMIT;
        end else begin
          resp_kind_d = KIND_ACK;
          state_d     = ST_RESP;
        end
      end
      ST_WK_EMIT: begin
        emit_kind = KIND_RELEASE;
        emit_grp  = GID_W'(rp_q);
        emit_all  = rp_p1 >= giu_q;
        emit_last = !(nxt_ok && (pend_rd_q == '0));
        if (out_free) begin
          emit = 1'b1;
          rp_d = rp_p1;
          n_d  = RES_CNT_W'(n_q + 1'b1);
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (rp_p2 < giu_q) begin
            pend_ren   = 1'b1;
            pend_raddr = rp_p2[GW-1:0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      armed_q <= 1'b0;
      rp_q    <= '0;
      giu_q   <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      rp_q    <= rp_d;
      giu_q   <= giu_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
    end
  end

  // Command and response holding
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    resp_kind_q <= resp_kind_d;
  end

  // Size valid bits; a group never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_v_q  <= '0;
      size_rv_q <= 1'b0;
    end else begin
      if (size_clr) begin
        size_v_q <= '0;
      end else if (size_wen) begin
        size_v_q[size_waddr] <= 1'b1;
      end
      if (size_ren) size_rv_q <= size_v_q[size_raddr];
    end
  end

  // Size store
  always_ff @(posedge clk_i) begin
    if (size_wen) size_mem[size_waddr] <= size_wdata;
    if (size_ren) size_rd_q <= size_mem[size_raddr];
  end

  // Pending store; only read while armed, after prepare has filled it
  always_ff @(posedge clk_i) begin
    if (pend_wen) pend_mem[pend_waddr] <= pend_wdata;
    if (pend_ren) pend_rd_q <= pend_mem[pend_raddr];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= emit_kind;
      out_grp_q  <= emit_grp;
      out_all_q  <= emit_all;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign released_group_o = out_grp_q;
  assign all_issued_o     = out_all_q;
  assign last_o           = out_last_q;

endmodule

[design/group_completion_in_order_release.sv]
// In-order group completion tracker, top level.
// Input channel (in_valid_i / in_stall_o): one word per op - clear, load an
// item into a group, prepare and arm, mark an item ready. Output channel
// (out_valid_o / out_stall_i): result words; last_o flags the final word of
// each input, and a mark may give up to MAX_RESULTS group releases.
// The front end holds each word while it classifies it through the item
// map read and takes no new one until it has pushed it into a two-entry
// queue; the back end executes it. Back-end steps per word: clear or error
// give one result; load reads and writes the group size store, first for
// the old group when the item leaves one; prepare sweeps the groups with a
// read and a write state each, copying the size store into the pending
// store; a mark is refused at once, or after the pending read on an extra
// mark, or counts down its group and walks the release pointer.
// Reset clears the map, sizes, pointer and arm state at once; no clearing
// pass is needed. While the receiver stalls, the result register holds its
// word, the back end waits, the queue fills and then the input stalls.
// Depends on gcior_pkg, gcior_front, gcior_queue, gcior_back.
module group_completion_in_order_release #(
  parameter int MAX_ITEMS  = gcior_pkg::MAX_ITEMS_DEF,
  parameter int MAX_GROUPS = gcior_pkg::MAX_GROUPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gcior_pkg::OP_W-1:0]   op_i,
  input  logic [gcior_pkg::ITEM_W-1:0] item_index_i,
  input  logic [gcior_pkg::GID_W-1:0]  group_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gcior_pkg::KIND_W-1:0] kind_o,
  output logic [gcior_pkg::GID_W-1:0]  released_group_o,
  output logic                         all_issued_o,
  output logic                         last_o
);
  import gcior_pkg::*;

  cmd_t push_data;
  cmd_t head_data;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;

  // Front end: accept and classify
  gcior_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .item_index_i (item_index_i),
    .group_id_i   (group_id_i),
    .cmd_o        (push_data),
    .cmd_push_o   (cmd_push),
    .cmd_full_i   (cmd_full)
  );

  // Command queue
  gcior_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (push_data),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (head_data),
    .empty_o (cmd_empty)
  );

  // Back end: counts, release walk, results
  gcior_back #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (head_data),
    .cmd_valid_i      (!cmd_empty),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .released_group_o (released_group_o),
    .all_issued_o     (all_issued_o),
    .last_o           (last_o)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for the in-order group release block.
// Directed table, then random load/prepare/mark rounds, checked against an
// in-bench tracker model. Depends on gcior_pkg and the DUT top level.
module tb_top;
  import gcior_pkg::*;

  localparam int N_ITEMS     = MAX_ITEMS_DEF;
  localparam int N_GROUPS    = MAX_GROUPS_DEF;
  localparam int RAND_WORDS  = 130;
  localparam int CALM_WORDS  = 30;
  localparam int TAIL_CYCLES = 100;

  // One result word as seen on the output channel
  typedef struct packed {
    kind_e             kind;
    logic [GID_W-1:0]  grp;
    logic              all_issued;
    logic              last;
  } result_t;

  // Directed stimulus row; expectation only used when typed is set
  typedef struct packed {
    op_e               op;
    logic [ITEM_W-1:0] item;
    logic [GID_W-1:0]  gid;
    logic              typed;
    kind_e             kind;
    logic [GID_W-1:0]  rgrp;
    logic              all_iss;
  } dir_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [OP_W-1:0]     op         = '0;
  logic [ITEM_W-1:0]   item_index = '0;
  logic [GID_W-1:0]    group_id   = '0;
  logic                out_stall  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [KIND_W-1:0]   kind;
  logic [GID_W-1:0]    released_group;
  logic                all_issued;
  logic                last;

  // Tracker model state
  logic [GID_W-1:0]    map_group [N_ITEMS];
  logic                map_valid [N_ITEMS];
  logic [SIZE_W-1:0]   size_of   [N_GROUPS];
  logic [SIZE_W-1:0]   pend_of   [N_GROUPS];
  int unsigned         rel_ptr;
  int unsigned         used_groups;
  logic                is_armed;

  result_t             step_res [$];
  result_t             release_exp_q [$];
  dir_row_t            dir_rows [$];
  int                  fail_count = 0;
  bit                  calm = 1'b0;

  group_completion_in_order_release DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .item_index_i     (item_index),
    .group_id_i       (group_id),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .released_group_o (released_group),
    .all_issued_o     (all_issued),
    .last_o           (last)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Tracker model
  // ---------------------------------------------------------------------
  function automatic void clear_tracker();
    for (int i = 0; i < N_ITEMS; i++) begin
      map_group[i] = '0;
      map_valid[i] = 1'b0;
    end
    for (int g = 0; g < N_GROUPS; g++) begin
      size_of[g] = '0;
      pend_of[g] = '0;
    end
    rel_ptr     = 0;
    used_groups = 0;
    is_armed    = 1'b0;
  endfunction

  // all_issued is taken after the release that this word reports
  function automatic void add_result(kind_e k, logic [GID_W-1:0] g);
    result_t r;
    r.kind       = k;
    r.grp        = g;
    r.all_issued = (rel_ptr >= used_groups);
    r.last       = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void predict_release(op_e op_w, logic [ITEM_W-1:0] item,
                                          logic [GID_W-1:0] gid);
    logic [GID_W-1:0] g;
    int unsigned      n;
    step_res.delete();
    case (op_w)
      OP_CLEAR: begin
        clear_tracker();
        add_result(KIND_ACK, '0);
      end
      OP_LOAD: begin
        if (int'(item) >= N_ITEMS || int'(gid) >= N_GROUPS) begin
          add_result(KIND_RANGE, '0);
        end else begin
          // a mapped item leaves its old group
          if (map_valid[item]) begin
            g = map_group[item];
            if (size_of[g] != '0) size_of[g] = size_of[g] - 1'b1;
          end
          map_group[item] = gid;
          map_valid[item] = 1'b1;
          if (size_of[gid] < SIZE_SAT) size_of[gid] = size_of[gid] + 1'b1;
          if (int'(gid) + 1 > int'(used_groups)) used_groups = int'(gid) + 1;
          add_result(KIND_ACK, '0);
        end
      end
      OP_PREP: begin
        is_armed = 1'b1;
        rel_ptr  = 0;
        for (int i = 0; i < N_GROUPS; i++) pend_of[i] = size_of[i];
        add_result(KIND_ACK, '0);
      end
      default: begin
        if (int'(item) >= N_ITEMS || !map_valid[item]) begin
          add_result(KIND_RANGE, '0);
        end else if (!is_armed) begin
          add_result(KIND_UNARMED, '0);
        end else begin
          g = map_group[item];
          if (int'(g) < int'(rel_ptr) || pend_of[g] == '0) begin
            add_result(KIND_ORDER, '0);
          end else begin
            pend_of[g] = pend_of[g] - 1'b1;
            // walk forward over every finished group
            n = 0;
            while (n < MAX_RESULTS && rel_ptr < used_groups &&
                   pend_of[rel_ptr] == '0) begin
              rel_ptr++;
              add_result(KIND_RELEASE, GID_W'(rel_ptr - 1));
              n++;
            end
            if (n == 0) add_result(KIND_ACK, '0);
          end
        end
      end
    endcase
    step_res[step_res.size()-1].last = 1'b1;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  task automatic send_word(op_e op_w, logic [ITEM_W-1:0] item,
                           logic [GID_W-1:0] gid, bit use_typed = 1'b0,
                           result_t typed_res = '0);
    // random idle burst before the word
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= op_w;
    item_index <= item;
    group_id   <= gid;
    do @(posedge clk); while (in_stall);
    predict_release(op_w, item, gid);
    if (use_typed) begin
      release_exp_q.insert(release_exp_q.size(), typed_res);
    end else begin
      foreach (step_res[i]) release_exp_q.insert(release_exp_q.size(), step_res[i]);
    end
  endtask

  // hold the sender back until every expected word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (release_exp_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall bursts, none in the calm tail
  // ---------------------------------------------------------------------
  initial begin
    int  hold;
    bit  stalled;
    hold    = 0;
    stalled = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
        stalled = 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else if (stalled) begin
        out_stall <= 1'b0;
        stalled = 1'b0;
        hold    = $urandom_range(1, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        stalled = 1'b1;
        hold    = $urandom_range(0, 14);
      end else begin
        hold = $urandom_range(1, 20);
      end
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (release_exp_q.size() == 0) begin
        $error("unexpected result word: kind %0d group %0d", kind, released_group);
        fail_count++;
      end else begin
        e = release_exp_q.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          fail_count++;
        end
        if (released_group !== e.grp) begin
          $error("released_group: expected %0d, got %0d", e.grp, released_group);
          fail_count++;
        end
        if (all_issued !== e.all_issued) begin
          $error("all_issued: expected %0d, got %0d", e.all_issued, all_issued);
          fail_count++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [ITEM_W-1:0] round_items [$];
    logic [ITEM_W-1:0] tmp;
    result_t           typed_res;
    int                sent;
    int                n_load;
    int                gmax;
    int                j;

    clear_tracker();

    // directed: error codes, extremes, moves, released groups, 32-word walk
    add_row('{OP_MARK,  8'd0,   5'd0,  1'b1, KIND_RANGE,   5'd0, 1'b1});
    add_row('{OP_PREP,  8'd0,   5'd0,  1'b1, KIND_ACK,     5'd0, 1'b1});
    add_row('{OP_CLEAR, 8'd0,   5'd0,  1'b1, KIND_ACK,     5'd0, 1'b1});
    add_row('{OP_LOAD,  8'd0,   5'd0,  1'b1, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_LOAD,  8'd255, 5'd31, 1'b1, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd0,   5'd0,  1'b1, KIND_UNARMED, 5'd0, 1'b0});
    add_row('{OP_LOAD,  8'd1,   5'd2,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_LOAD,  8'd2,   5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_LOAD,  8'd2,   5'd3,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_PREP,  8'd0,   5'd0,  1'b1, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd1,   5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd1,   5'd0,  1'b1, KIND_ORDER,   5'd0, 1'b0});
    add_row('{OP_MARK,  8'd0,   5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd0,   5'd0,  1'b1, KIND_ORDER,   5'd0, 1'b0});
    add_row('{OP_MARK,  8'd2,   5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd255, 5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_LOAD,  8'd3,   5'd5,  1'b1, KIND_ACK,     5'd0, 1'b1});
    add_row('{OP_MARK,  8'd3,   5'd0,  1'b1, KIND_ORDER,   5'd0, 1'b1});
    add_row('{OP_PREP,  8'd0,   5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_CLEAR, 8'd0,   5'd0,  1'b1, KIND_ACK,     5'd0, 1'b1});
    add_row('{OP_LOAD,  8'd10,  5'd31, 1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_PREP,  8'd0,   5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd10,  5'd0,  1'b0, KIND_ACK,     5'd0, 1'b0});
    add_row('{OP_MARK,  8'd10,  5'd0,  1'b1, KIND_ORDER,   5'd0, 1'b1});
    add_row('{OP_MARK,  8'd77,  5'd0,  1'b1, KIND_RANGE,   5'd0, 1'b1});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_res.kind       = dir_rows[i].kind;
      typed_res.grp        = dir_rows[i].rgrp;
      typed_res.all_issued = dir_rows[i].all_iss;
      typed_res.last       = 1'b1;
      send_word(dir_rows[i].op, dir_rows[i].item, dir_rows[i].gid,
                dir_rows[i].typed, typed_res);
    end
    drain_results();

    // random rounds: mostly clear, load, prepare, mark all in shuffled order
    sent = 0;
    while (sent < RAND_WORDS) begin
      calm = (sent >= RAND_WORDS - CALM_WORDS);
      if ($urandom_range(0, 3) != 0) begin
        send_word(OP_CLEAR, ITEM_W'($urandom), GID_W'($urandom));
        sent++;
      end
      round_items.delete();
      n_load = $urandom_range(1, 10);
      gmax   = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(0, 7);
      for (int k = 0; k < n_load; k++) begin
        tmp = ITEM_W'($urandom_range(0, 255));
        send_word(OP_LOAD, tmp, GID_W'($urandom_range(0, gmax)));
        round_items.insert(round_items.size(), tmp);
        sent++;
      end
      // early mark, unarmed or of an unmapped item
      if ($urandom_range(0, 4) == 0) begin
        send_word(OP_MARK, ITEM_W'($urandom), GID_W'($urandom));
        sent++;
      end
      send_word(OP_PREP, ITEM_W'($urandom), GID_W'($urandom));
      sent++;
      for (int k = round_items.size() - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = round_items[k];
        round_items[k] = round_items[j];
        round_items[j] = tmp;
      end
      foreach (round_items[k]) begin
        send_word(OP_MARK, round_items[k], GID_W'($urandom));
        sent++;
        // noise: repeat mark, stray mark or load while armed
        case ($urandom_range(0, 9))
          0: begin
            send_word(OP_MARK, round_items[k], GID_W'($urandom));
            sent++;
          end
          1: begin
            send_word(OP_MARK, ITEM_W'($urandom), GID_W'($urandom));
            sent++;
          end
          2: begin
            send_word(OP_LOAD, ITEM_W'($urandom), GID_W'($urandom_range(0, gmax)));
            sent++;
          end
          default: ;
        endcase
      end
      if (!calm && $urandom_range(0, 3) == 0) drain_results();
    end

    in_valid <= 1'b0;
    while (release_exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
